FILE: hw/rtl/bfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types, constants and the reciprocal table of the box filter
// downsampler
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_FACTOR  = 8;
    localparam int NUM_CHAN    = 4;

    localparam int CHAN_W      = 8;
    localparam int K_W         = 4;
    localparam int FMT_W       = 2;
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SUB_W       = $clog2(MAX_FACTOR);
    localparam int BSUM_W      = 11;   // 8 columns of 8-bit samples
    localparam int LSUM_W      = 14;   // 8 x 8 samples
    localparam int LINE_W      = NUM_CHAN * LSUM_W;

    // floor(s / (k*k)) = (s * ceil(2^21 / (k*k))) >> 21 for s < 2^14
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W      = LSUM_W + RECIP_W;

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT = 8'd3;

    localparam logic [FMT_W-1:0] FMT_ONE   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_THREE = 2'd1;

    localparam logic [K_W-1:0]      RST_OVERSAMPLE   = 4'd2;
    localparam logic [FMT_W-1:0]    RST_PIXEL_FORMAT = FMT_ONE;
    localparam logic [WIDTH_W-1:0]  RST_INPUT_WIDTH  = 13'd4096;
    localparam logic [HEIGHT_W-1:0] RST_INPUT_HEIGHT = 16'd4096;

    typedef struct packed {
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_c;
        logic [CHAN_W-1:0] chan_d;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] avg_a;
        logic [CHAN_W-1:0] avg_b;
        logic [CHAN_W-1:0] avg_c;
        logic [CHAN_W-1:0] avg_d;
        logic              row_end;
        logic              frame_end;
    } pixel_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCALE,
        ST_EMIT
    } bfd_state_t;

    typedef struct packed {
        logic accept;      // take the input item, step counters, launch read
        logic line_write;  // write back the line accumulator
        logic scale;       // multiply sums by the reciprocal
        logic emit;        // load the output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic seg_update;  // current input item closes a row segment of a block
        logic blk_end;     // the pending segment closes the whole block
        logic out_free;    // output register can take a new item
    } dp_status_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [K_W-1:0] k);
        logic [RECIP_W-1:0] r;
        unique case (k)
            4'd1:    r = 22'd2097152;
            4'd2:    r = 22'd524288;
            4'd3:    r = 22'd233017;
            4'd4:    r = 22'd131072;
            4'd5:    r = 22'd83887;
            4'd6:    r = 22'd58255;
            4'd7:    r = 22'd42800;
            4'd8:    r = 22'd32768;
            default: r = 22'd2097152;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/bfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bfd_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/bfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_ctrl
// sequencer: accept, line accumulator update, scaling, output load
// ----------------------------------------------------------------------------
module bfd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfd_pkg::dp_status_t status,
    output bfd_pkg::ctrl_cmd_t  cmd
);

    bfd_pkg::bfd_state_t state_reg;
    bfd_pkg::bfd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bfd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bfd_pkg::ST_IDLE: begin
                if (s_valid && status.seg_update) begin
                    state_next = bfd_pkg::ST_UPDATE;
                end
            end
            bfd_pkg::ST_UPDATE: begin
                state_next = status.blk_end ? bfd_pkg::ST_SCALE : bfd_pkg::ST_IDLE;
            end
            bfd_pkg::ST_SCALE: begin
                state_next = bfd_pkg::ST_EMIT;
            end
            bfd_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = bfd_pkg::ST_IDLE;
                end
            end
            default: state_next = bfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            bfd_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            bfd_pkg::ST_UPDATE: cmd.line_write = 1'b1;
            bfd_pkg::ST_SCALE:  cmd.scale      = 1'b1;
            bfd_pkg::ST_EMIT:   cmd.emit       = status.out_free;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/bfd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_datapath
// config registers, position counters, block and line sums, scaling and
// output register
// ----------------------------------------------------------------------------
module bfd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  bfd_pkg::pixel_in_t                s_data,
    input  bfd_pkg::ctrl_cmd_t                cmd,
    output bfd_pkg::dp_status_t               status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output bfd_pkg::pixel_out_t               m_data
);

    localparam int NC   = bfd_pkg::NUM_CHAN;
    localparam int CW   = bfd_pkg::CHAN_W;
    localparam int KW   = bfd_pkg::K_W;
    localparam int WW   = bfd_pkg::WIDTH_W;
    localparam int HW   = bfd_pkg::HEIGHT_W;
    localparam int COLW = bfd_pkg::COL_W;
    localparam int SW   = bfd_pkg::SUB_W;
    localparam int BW   = bfd_pkg::BSUM_W;
    localparam int LW   = bfd_pkg::LSUM_W;
    localparam int RW   = bfd_pkg::RECIP_W;
    localparam int PW   = bfd_pkg::PROD_W;
    localparam int RS   = bfd_pkg::RECIP_SHIFT;
    localparam int XW   = WW + 1;
    localparam int YW   = HW + 2;

    // configuration
    logic [KW-1:0]             oversample_reg;
    logic [bfd_pkg::FMT_W-1:0] pixel_format_reg;
    logic [WW-1:0]             input_width_reg;
    logic [HW-1:0]             input_height_reg;
    logic [KW-1:0]             k_eff;
    logic [WW-1:0]             w_eff;
    logic [HW-1:0]             h_eff;

    // position
    logic [COLW-1:0] col_base_reg, col_base_next;
    logic [COLW-1:0] col_pos_reg,  col_pos_next;
    logic [SW-1:0]   sub_col_reg,  sub_col_next;
    logic [HW-1:0]   row_base_reg, row_base_next;
    logic [SW-1:0]   sub_row_reg,  sub_row_next;

    logic x_last, y_last, in_col, in_row, in_block;
    logic seg_end, blk_end, col_last, row_last;

    // sums
    logic [NC-1:0][CW-1:0] pix;
    logic [NC-1:0][BW-1:0] block_sum_reg;
    logic [NC-1:0][LW-1:0] line_rd;
    logic [NC-1:0][LW-1:0] line_new;
    logic [NC-1:0][LW-1:0] sum_reg;
    logic [NC-1:0][PW-1:0] prod;
    logic [NC-1:0][CW-1:0] quot_reg;
    logic [RW-1:0]         recip_reg;

    logic [COLW-1:0] addr_reg;
    logic            first_row_reg;
    logic            blk_end_reg;
    logic            row_end_reg;
    logic            frame_end_reg;

    logic                m_valid_reg;
    bfd_pkg::pixel_out_t m_data_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oversample_reg   <= bfd_pkg::RST_OVERSAMPLE;
            pixel_format_reg <= bfd_pkg::RST_PIXEL_FORMAT;
            input_width_reg  <= bfd_pkg::RST_INPUT_WIDTH;
            input_height_reg <= bfd_pkg::RST_INPUT_HEIGHT;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                bfd_pkg::REG_OVERSAMPLE:   oversample_reg   <= cfg_data[KW-1:0];
                bfd_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[bfd_pkg::FMT_W-1:0];
                bfd_pkg::REG_INPUT_WIDTH:  input_width_reg  <= cfg_data[WW-1:0];
                bfd_pkg::REG_INPUT_HEIGHT: input_height_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    logic cfg_restart;
    assign cfg_restart = cfg_wr && (cfg_index == bfd_pkg::REG_OVERSAMPLE
                                 || cfg_index == bfd_pkg::REG_PIXEL_FORMAT
                                 || cfg_index == bfd_pkg::REG_INPUT_WIDTH
                                 || cfg_index == bfd_pkg::REG_INPUT_HEIGHT);

    always_comb begin
        if (oversample_reg == '0) begin
            k_eff = KW'(1);
        end else if (oversample_reg > KW'(bfd_pkg::MAX_FACTOR)) begin
            k_eff = KW'(bfd_pkg::MAX_FACTOR);
        end else begin
            k_eff = oversample_reg;
        end
        if (input_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (input_width_reg > WW'(bfd_pkg::MAX_WIDTH)) begin
            w_eff = WW'(bfd_pkg::MAX_WIDTH);
        end else begin
            w_eff = input_width_reg;
        end
        h_eff = (input_height_reg == '0) ? HW'(1) : input_height_reg;
    end

    // ---------------- position decode ----------------
    always_comb begin
        x_last   = (XW'(col_base_reg) + XW'(sub_col_reg) + XW'(1)) >= XW'(w_eff);
        y_last   = (YW'(row_base_reg) + YW'(sub_row_reg) + YW'(1)) >= YW'(h_eff);
        in_col   = (XW'(col_base_reg) + XW'(k_eff)) <= XW'(w_eff);
        in_row   = (YW'(row_base_reg) + YW'(k_eff)) <= YW'(h_eff);
        col_last = (XW'(col_base_reg) + XW'({k_eff, 1'b0})) > XW'(w_eff);
        row_last = (YW'(row_base_reg) + YW'({k_eff, 1'b0})) > YW'(h_eff);
        in_block = in_col && in_row;
        seg_end  = (KW'(sub_col_reg) + KW'(1)) >= k_eff;
        blk_end  = (KW'(sub_row_reg) + KW'(1)) >= k_eff;
    end

    always_comb begin
        col_base_next = col_base_reg;
        col_pos_next  = col_pos_reg;
        sub_col_next  = sub_col_reg;
        row_base_next = row_base_reg;
        sub_row_next  = sub_row_reg;
        if (x_last) begin
            col_base_next = '0;
            col_pos_next  = '0;
            sub_col_next  = '0;
            if (y_last) begin
                row_base_next = '0;
                sub_row_next  = '0;
            end else if (blk_end) begin
                sub_row_next  = '0;
                row_base_next = row_base_reg + HW'(k_eff);
            end else begin
                sub_row_next  = sub_row_reg + SW'(1);
            end
        end else if (seg_end) begin
            sub_col_next  = '0;
            col_base_next = col_base_reg + COLW'(k_eff);
            col_pos_next  = col_pos_reg + COLW'(1);
        end else begin
            sub_col_next  = sub_col_reg + SW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_restart) begin
            col_base_reg <= '0;
            col_pos_reg  <= '0;
            sub_col_reg  <= '0;
            row_base_reg <= '0;
            sub_row_reg  <= '0;
        end else if (cmd.accept) begin
            col_base_reg <= col_base_next;
            col_pos_reg  <= col_pos_next;
            sub_col_reg  <= sub_col_next;
            row_base_reg <= row_base_next;
            sub_row_reg  <= sub_row_next;
        end
    end

    // ---------------- block sum ----------------
    always_comb begin
        pix = {s_data.chan_d, s_data.chan_c, s_data.chan_b, s_data.chan_a};
        unique case (pixel_format_reg)
            bfd_pkg::FMT_ONE: begin
                pix[1] = '0;
                pix[2] = '0;
                pix[3] = '0;
            end
            bfd_pkg::FMT_THREE: pix[3] = '0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && in_block) begin
            for (int c = 0; c < NC; c++) begin
                block_sum_reg[c] <= (sub_col_reg == '0) ? BW'(pix[c])
                                                         : block_sum_reg[c] + BW'(pix[c]);
            end
        end
        if (cmd.accept) begin
            addr_reg      <= col_pos_reg;
            first_row_reg <= (sub_row_reg == '0);
            blk_end_reg   <= blk_end;
            row_end_reg   <= col_last;
            frame_end_reg <= col_last && row_last;
        end
    end

    assign status.seg_update = in_block && seg_end;
    assign status.blk_end    = blk_end_reg;
    assign status.out_free   = !m_valid_reg || m_ready;

    // ---------------- line accumulators ----------------
    logic [bfd_pkg::LINE_W-1:0] ram_rd_data;

    bfd_ram #(
        .WIDTH (bfd_pkg::LINE_W),
        .DEPTH (bfd_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (cmd.line_write),
        .wr_addr (addr_reg),
        .wr_data (line_new),
        .rd_en   (cmd.accept),
        .rd_addr (col_pos_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        line_rd = ram_rd_data;
        for (int c = 0; c < NC; c++) begin
            line_new[c] = first_row_reg ? LW'(block_sum_reg[c])
                                        : line_rd[c] + LW'(block_sum_reg[c]);
        end
    end

    // ---------------- scaling ----------------
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            prod[c] = PW'(sum_reg[c]) * PW'(recip_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.line_write) begin
            sum_reg   <= line_new;
            recip_reg <= bfd_pkg::recip_of(k_eff);
        end
        if (cmd.scale) begin
            for (int c = 0; c < NC; c++) begin
                quot_reg[c] <= prod[c][RS +: CW];
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.avg_a     <= quot_reg[0];
            m_data_reg.avg_b     <= quot_reg[1];
            m_data_reg.avg_c     <= quot_reg[2];
            m_data_reg.avg_d     <= quot_reg[3];
            m_data_reg.row_end   <= row_end_reg;
            m_data_reg.frame_end <= frame_end_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/box_filter_downsampler_unit.sv
`timescale 1ns / 1ps
// result path: a block's closing item passes line update, scaling, output load
// throughput: items inside a block row segment are taken back to back; an item
//   that ends a segment adds a line update (read-modify-write of the single line
//   accumulator ram), one ending a block also scaling, output load, any stall
// reset: aresetn synchronous active low; registers take their reset values,
//   position counters clear, line accumulators keep their contents
// ----------------------------------------------------------------------------
// box_filter_downsampler_unit
// K by K box filter downsampler for 1, 3 or 4 channel raster pixel streams
// ----------------------------------------------------------------------------
module box_filter_downsampler_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data,

    // input pixel items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bfd_pkg::pixel_in_t             s_data,

    // averaged pixel items
    output logic                           m_valid,
    input  logic                           m_ready,
    output bfd_pkg::pixel_out_t            m_data
);

    bfd_pkg::ctrl_cmd_t  cmd;
    bfd_pkg::dp_status_t status;
    logic                cfg_wr;

    // the user writes registers only while the block is idle; the block does not
    // enforce it. cfg_ready is tied high, so the write channel never backs up
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // sequencer: idle (taking items), line update, scaling, output load
    bfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // counters, block sum, line accumulator ram, reciprocal scaling and
    // the output register that decouples the result side
    bfd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: hw/rtl/bfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_checker
// port level checks on the result channel of the downsampler
// ----------------------------------------------------------------------------
module bfd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input bfd_pkg::pixel_out_t m_data
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // end of frame is always also end of an output row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.frame_end || m_data.row_end))
        else $error("frame end without row end");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind box_filter_downsampler_unit bfd_checker u_bfd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
